### rtl/ppr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ppr_pkg;

  localparam int unsigned TICK_W   = 32;
  localparam int unsigned RATE_W   = 16;
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;
  localparam int unsigned STEP_W   = $clog2(TICK_W);

  localparam logic [TICK_W-1:0] TPM_RESET = TICK_W'(60000000);
  localparam logic [RATE_W-1:0] RATE_MAX  = {RATE_W{1'b1}};

  // Register word index (paddr above the byte offset)
  localparam logic [PADDR_W-3:0] REG_TICKS_PER_MINUTE = '0;

endpackage

`default_nettype wire

### rtl/ppr_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ppr_in_if;
  logic valid;
  logic ready;
  logic pulse_in;

  modport source (output valid, output pulse_in, input ready);
  modport sink   (input valid, input pulse_in, output ready);
endinterface

`default_nettype wire

### rtl/ppr_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ppr_out_if;
  logic                        valid;
  logic                        ready;
  logic [ppr_pkg::RATE_W-1:0]  rate_bpm;
  logic                        new_rate;

  modport source (output valid, output rate_bpm, output new_rate, input ready);
  modport sink   (input valid, input rate_bpm, input new_rate, output ready);
endinterface

`default_nettype wire

### rtl/pulse_period_rate_meter.sv
`timescale 1ns / 1ps
`default_nettype none

// Pulse period rate meter. Each beat on the pulse channel is one timer tick
// carrying the sampled sensor level; each tick yields exactly one beat on the
// rate channel. A 32-bit counter tracks ticks since the last rising edge and
// wraps mod 2^32. On a rising edge the period (count + 1) divides
// ticks_per_minute through a restoring divider that resolves one quotient bit
// per cycle, the quotient saturates to 65535 (a zero period saturates too),
// and the result is flagged with new_rate. A tick without an edge is accepted
// and its result is registered the next cycle; an edge tick holds the pulse
// channel off while the divider runs and its result is registered on the last
// divide step. The divider is the only long path; while it runs no tick is
// taken. The output register lets the next tick enter in the cycle the pending
// result is taken. ticks_per_minute (APB byte address 0, reset 60000000) is
// readable and must be written only while idle; the block does not enforce it.
module pulse_period_rate_meter
  import ppr_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst,
  ppr_in_if.sink                            pulse,
  ppr_out_if.source                         rate,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [ppr_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [ppr_pkg::PDATA_W-1:0]  pwdata,
  output logic      [ppr_pkg::PDATA_W-1:0]  prdata,
  output logic                              pready
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DIV  = 1'b1;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(TICK_W - 1);

  // Control state
  logic                state;
  logic                last_level;
  logic [TICK_W-1:0]   elapsed_ticks;
  logic [RATE_W-1:0]   held_rate;
  logic [TICK_W-1:0]   ticks_per_minute;
  logic [STEP_W-1:0]   step;
  logic                out_valid;
  logic                out_valid_next;

  // Datapath registers
  logic [TICK_W-1:0]   period;
  logic [TICK_W-1:0]   acc;        // partial remainder
  logic [TICK_W-1:0]   dq;         // dividend bits out, quotient bits in
  logic [RATE_W-1:0]   out_rate;
  logic                out_new;

  logic                accept;
  logic                edge_seen;
  logic                cfg_write;
  logic [TICK_W:0]     rem_shift;
  logic [TICK_W+1:0]   trial;
  logic                q_bit;
  logic [TICK_W-1:0]   acc_next;
  logic [TICK_W-1:0]   quotient;
  logic [RATE_W-1:0]   rate_sat;

  // Take a tick only while idle and with the output register free or draining
  assign pulse.ready = (state == ST_IDLE) && (!out_valid || rate.ready);
  assign accept      = pulse.valid && pulse.ready;
  assign edge_seen   = pulse.pulse_in && !last_level;

  assign rate.valid    = out_valid;
  assign rate.rate_bpm = out_rate;
  assign rate.new_rate = out_new;

  assign cfg_write = psel && penable && pwrite
                     && (paddr[PADDR_W-1:2] == REG_TICKS_PER_MINUTE);
  assign pready    = 1'b1;

  always_comb begin
    if (paddr[PADDR_W-1:2] == REG_TICKS_PER_MINUTE) begin
      prdata = PDATA_W'(ticks_per_minute);
    end else begin
      prdata = '0;
    end
  end

  // Drop the pending beat when taken; a plain tick or the last divide step
  // loads a new one
  always_comb begin
    out_valid_next = out_valid;
    if (rate.valid && rate.ready) begin
      out_valid_next = 1'b0;
    end
    if ((state == ST_IDLE) && accept && !edge_seen) begin
      out_valid_next = 1'b1;
    end
    if ((state == ST_DIV) && (step == LAST_STEP)) begin
      out_valid_next = 1'b1;
    end
  end

  // One restoring step: shift in the next dividend bit, try the subtract
  assign rem_shift = {acc, dq[TICK_W-1]};
  assign trial     = {1'b0, rem_shift} - {2'b00, period};
  assign q_bit     = ~trial[TICK_W+1];
  assign acc_next  = q_bit ? trial[TICK_W-1:0] : rem_shift[TICK_W-1:0];
  assign quotient  = {dq[TICK_W-2:0], q_bit};
  // A zero period leaves an all-ones quotient, so it saturates here as well
  assign rate_sat  = (|quotient[TICK_W-1:RATE_W]) ? RATE_MAX : quotient[RATE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      last_level       <= 1'b0;
      elapsed_ticks    <= '0;
      held_rate        <= '0;
      ticks_per_minute <= TPM_RESET;
      step             <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_write) begin
        ticks_per_minute <= pwdata[TICK_W-1:0];
      end
      out_valid <= out_valid_next;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            last_level <= pulse.pulse_in;
            if (edge_seen) begin
              // restart the count and launch the divide
              elapsed_ticks <= '0;
              step          <= '0;
              state         <= ST_DIV;
            end else begin
              elapsed_ticks <= elapsed_ticks + 1'b1;
            end
          end
        end
        ST_DIV: begin
          step <= step + 1'b1;
          if (step == LAST_STEP) begin
            held_rate <= rate_sat;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      if (accept) begin
        if (edge_seen) begin
          period <= elapsed_ticks + 1'b1;
          acc    <= '0;
          dq     <= ticks_per_minute;
        end else begin
          out_rate <= held_rate;
          out_new  <= 1'b0;
        end
      end
    end else begin
      acc <= acc_next;
      dq  <= quotient;
      if (step == LAST_STEP) begin
        out_rate <= rate_sat;
        out_new  <= 1'b1;
      end
    end
  end

  // Hold the pulse channel off for the whole divide
  a_no_take_while_div: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> !pulse.ready)
    else $error("tick taken while divider busy");

  // The output register stays empty while a divide is in flight
  a_out_empty_div: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> !out_valid)
    else $error("result pending during divide");

  // The last divide step delivers a fresh reading
  a_div_result: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && step == LAST_STEP) |=> (out_valid && out_new && state == ST_IDLE))
    else $error("divide did not produce a fresh reading");

  // A tick without a rising edge gives the held rate on the next cycle
  a_plain_tick: assert property (@(posedge clk) disable iff (rst)
    (accept && !edge_seen) |=> (out_valid && !out_new && out_rate == held_rate))
    else $error("non-edge tick result wrong");

  // Every edge tick starts the divide from a cleared counter
  a_edge_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && edge_seen) |=> (state == ST_DIV && elapsed_ticks == '0 && step == '0))
    else $error("edge tick did not launch divide");

endmodule

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import ppr_pkg::*;

  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned HOLD_OFF    = 400;
  localparam int unsigned DRAIN_TAIL  = 40;
  localparam int unsigned PHASE_TICKS = 275;

  typedef struct {
    logic [RATE_W-1:0] rate_bpm;
    logic              new_rate;
  } rate_reading_t;

  // Track the meter's own state: last level, tick count since the last
  // rising edge, and the held rate. Each tick queues the reading it must
  // produce, and readings coming out are matched in order.
  class tick_rate_tracker;
    logic [TICK_W-1:0] ticks_per_minute;
    logic              last_level;
    logic [TICK_W-1:0] elapsed_ticks;
    logic [RATE_W-1:0] held_rate;
    rate_reading_t     readings_due[$];
    int unsigned       mismatches;

    function new();
      ticks_per_minute = TPM_RESET;
      last_level       = 1'b0;
      elapsed_ticks    = '0;
      held_rate        = '0;
      mismatches       = 0;
    endfunction

    function void set_ticks_per_minute(logic [TICK_W-1:0] value);
      ticks_per_minute = value;
    endfunction

    function void take_tick(logic level);
      logic [TICK_W-1:0] period;
      logic [TICK_W-1:0] quot;
      rate_reading_t     reading;
      period           = elapsed_ticks + 1'b1;
      reading.new_rate = 1'b0;
      if (level && !last_level) begin
        if (period == '0) begin
          held_rate = RATE_MAX;
        end else begin
          quot      = ticks_per_minute / period;
          held_rate = (quot > TICK_W'(RATE_MAX)) ? RATE_MAX : quot[RATE_W-1:0];
        end
        elapsed_ticks    = '0;
        reading.new_rate = 1'b1;
      end else begin
        elapsed_ticks = period;
      end
      last_level       = level;
      reading.rate_bpm = held_rate;
      readings_due.push_back(reading);
    endfunction

    function void match_reading(logic [RATE_W-1:0] rate_bpm, logic new_rate);
      rate_reading_t due;
      if (readings_due.size() == 0) begin
        $error("rate beat with no tick pending: rate_bpm=%0d new_rate=%0b",
               rate_bpm, new_rate);
        mismatches++;
        return;
      end
      due = readings_due.pop_front();
      if (rate_bpm !== due.rate_bpm) begin
        $error("rate_bpm: expected %0d, got %0d", due.rate_bpm, rate_bpm);
        mismatches++;
      end
      if (new_rate !== due.new_rate) begin
        $error("new_rate: expected %0b, got %0b", due.new_rate, new_rate);
        mismatches++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  ppr_in_if  pulse_if ();
  ppr_out_if rate_if ();

  pulse_period_rate_meter dut (
    .clk     (clk),
    .rst     (rst),
    .pulse   (pulse_if),
    .rate    (rate_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  tick_rate_tracker tracker = new();

  int unsigned burst_left    = 0;
  bit          hold_off_req  = 1'b0;
  int unsigned quiet_cycles  = 0;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Offer one tick; most burst boundaries drop valid for a random gap. Return at
  // the falling edge after the beat, so the next tick can keep valid high.
  task automatic send_tick(input logic level);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      if ($urandom_range(0, 2) != 0) begin
        pulse_if.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
    pulse_if.valid    <= 1'b1;
    pulse_if.pulse_in <= level;
    do @(posedge clk); while (!pulse_if.ready);
    tracker.take_tick(level);
    burst_left--;
    @(negedge clk);
  endtask

  // Send the low n bits of a level pattern, oldest tick in the top bit.
  task automatic send_pattern(input logic [31:0] levels, input int n);
    for (int k = n - 1; k >= 0; k--) send_tick(levels[k]);
  endtask

  // Drop valid and wait until every reading has come back; every tick
  // yields a beat, so an empty queue means the meter is idle.
  task automatic drain();
    pulse_if.valid <= 1'b0;
    do @(negedge clk); while (tracker.readings_due.size() != 0);
  endtask

  // APB write of ticks_per_minute, setup phase then access phase; the register
  // takes the value at the access-phase edge.
  task automatic write_ticks_per_minute(input logic [TICK_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_TICKS_PER_MINUTE, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracker.set_ticks_per_minute(value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Mostly well-formed pulse trains: a low stretch then a high stretch,
  // with an occasional very long period or long high level. The rest is
  // noise with single-tick glitches.
  task automatic random_run(input int unsigned count);
    int unsigned sent;
    int unsigned span;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 9) == 0) begin
        span = $urandom_range(1, 6);
        if (span > count - sent) span = count - sent;
        repeat (span) send_tick(1'($urandom_range(0, 1)));
        sent += span;
      end else begin
        span = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 1500)
                                           : $urandom_range(1, 40);
        if (span > count - sent) span = count - sent;
        repeat (span) send_tick(1'b0);
        sent += span;
        span = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300)
                                           : $urandom_range(1, 12);
        if (span > count - sent) span = count - sent;
        repeat (span) send_tick(1'b1);
        sent += span;
      end
    end
  endtask

  // Main sequence: reset, a short directed part across register settings,
  // then random pulse trains under several ticks_per_minute values.
  initial begin : stimulus
    logic [TICK_W-1:0] settings [7];
    rst               = 1'b1;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    pulse_if.valid    = 1'b0;
    pulse_if.pulse_in = 1'b0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset rate: first edge counts from reset and saturates, a level held
    // high sees no edge, then short periods saturate too.
    send_pattern(32'b0011110101, 10);
    drain();
    // Zero numerator: every rate computed on an edge reads 0.
    write_ticks_per_minute('0);
    send_pattern(32'b00101, 5);
    drain();
    write_ticks_per_minute(TICK_W'(1));
    send_pattern(32'b0101, 4);
    drain();
    write_ticks_per_minute('1);
    send_pattern(32'b011, 3);
    drain();
    // Unsaturated rate: 1000 / 4 after a low stretch.
    write_ticks_per_minute(TICK_W'(1000));
    send_pattern(32'b001, 3);
    drain();

    settings = '{TPM_RESET, TICK_W'(1000), TICK_W'(1), '1,
                 TICK_W'($urandom_range(1000, 2000000)), TICK_W'($urandom()),
                 TICK_W'(600000)};
    foreach (settings[i]) begin
      write_ticks_per_minute(settings[i]);
      // Stall the rate side for a long stretch early in one phase, so the
      // meter backs up and holds off the pulse channel.
      if (i == 1) hold_off_req = 1'b1;
      random_run(PHASE_TICKS);
      drain();
    end

    repeat (DRAIN_TAIL) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Rate-side ready: stretches of always ready, coin flips, mostly stalled and
  // mostly ready, plus one long hold-off on request.
  initial begin : rate_sink
    int unsigned mode;
    int unsigned stretch;
    rate_if.ready = 1'b0;
    forever begin
      mode    = $urandom_range(0, 3);
      stretch = $urandom_range(10, 150);
      repeat (stretch) begin
        @(negedge clk);
        if (hold_off_req) begin
          hold_off_req = 1'b0;
          rate_if.ready <= 1'b0;
          repeat (HOLD_OFF) @(negedge clk);
        end
        case (mode)
          0: begin
            rate_if.ready <= 1'b1;
          end
          1: begin
            rate_if.ready <= 1'($urandom_range(0, 1));
          end
          2: begin
            rate_if.ready <= ($urandom_range(0, 3) == 0);
          end
          default: begin
            rate_if.ready <= ($urandom_range(0, 7) != 0);
          end
        endcase
      end
    end
  end

  // Check every rate beat against the oldest pending reading.
  always @(posedge clk) begin
    if (!rst && rate_if.valid && rate_if.ready) begin
      tracker.match_reading(rate_if.rate_bpm, rate_if.new_rate);
    end
  end

  // Watchdog: end the run when no beat moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (pulse_if.valid && pulse_if.ready) || (rate_if.valid && rate_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
